FILE: rtl/ellipse_sector_point_test_defines.svh
// Assertion helpers for the ellipse sector point test.
`ifndef ELLIPSE_SECTOR_POINT_TEST_DEFINES_SVH
`define ELLIPSE_SECTOR_POINT_TEST_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define ESP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that one condition implies another on the same edge.
`define ESP_IMPLY(lbl, cond, cons, msg) \
    `ESP_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

FILE: rtl/esp_pkg.sv
`default_nettype none
package esp_pkg;
    localparam int COORD_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int STEPS    = 16;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int ROT_W    = 34;
    localparam int VEC_W    = DIFF_W + 19;
    localparam int PROD_W   = DIFF_W + ROT_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int MAG_W    = SUM_W - 30;
    localparam logic signed [ROT_W-1:0] CORDIC_START_X = ROT_W'(652032874);
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_AXIS_FIRST  = 3'd2,
        REG_AXIS_SECOND = 3'd3,
        REG_ORIENTATION = 3'd4,
        REG_START_ANGLE = 3'd5,
        REG_END_ANGLE   = 3'd6,
        REG_SECTOR_EN   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_delta;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] r;
        unique case (i)
            4'd0:  r = 32'd536870912;
            4'd1:  r = 32'd316933406;
            4'd2:  r = 32'd167458907;
            4'd3:  r = 32'd85004756;
            4'd4:  r = 32'd42667331;
            4'd5:  r = 32'd21354465;
            4'd6:  r = 32'd10679838;
            4'd7:  r = 32'd5340245;
            4'd8:  r = 32'd2670163;
            4'd9:  r = 32'd1335087;
            4'd10: r = 32'd667544;
            4'd11: r = 32'd333772;
            4'd12: r = 32'd166886;
            4'd13: r = 32'd83443;
            4'd14: r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/esp_front.sv
`default_nettype none
module esp_front import esp_pkg::*; (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire  [2*COORD_W-1:0]      s_axis_tdata,
    input  wire  signed [COORD_W-1:0] i_center_x,
    input  wire  signed [COORD_W-1:0] i_center_y,
    input  t_q_stat                   i_q_stat,
    output logic                      o_push,
    output t_delta                    o_delta
);
    logic signed [COORD_W-1:0] w_px, w_py;
    logic                      r_open;

    // The front stays closed in reset and opens when r_open is set at the first clock edge outside it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= 1'b1;
        end
    end

    assign w_px = $signed(s_axis_tdata[COORD_W-1:0]);
    assign w_py = $signed(s_axis_tdata[2*COORD_W-1:COORD_W]);
    assign s_axis_tready = r_open && !i_q_stat.full;
    assign o_push = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_delta.dx = DIFF_W'(w_px) - DIFF_W'(i_center_x);
        o_delta.dy = DIFF_W'(w_py) - DIFF_W'(i_center_y);
    end
endmodule
`default_nettype wire

FILE: rtl/esp_queue.sv
`default_nettype none
module esp_queue import esp_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    input  t_delta  i_data,
    input  wire     i_pop,
    output t_delta  o_data,
    output t_q_stat o_stat
);
    t_delta             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_cnt;
    logic               w_pop;

    assign w_pop = i_pop && (r_cnt != '0);
    assign o_stat.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/esp_back.sv
`default_nettype none
module esp_back import esp_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_q_stat            i_q_stat,
    input  t_delta             i_delta,
    output logic               o_pop,
    input  wire [COORD_W-1:0]  i_axis_first,
    input  wire [COORD_W-1:0]  i_axis_second,
    input  wire [ANGLE_W-1:0]  i_orientation,
    input  wire [ANGLE_W-1:0]  i_start_angle,
    input  wire [ANGLE_W-1:0]  i_end_angle,
    input  wire                i_sector_en,
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [7:0]         m_axis_tdata
);
    logic en;

    // CORDIC stage registers: index k holds the values before step k.
    logic                      r_v  [STEPS+1];
    logic signed [DIFF_W-1:0]  r_dx [STEPS+1];
    logic signed [DIFF_W-1:0]  r_dy [STEPS+1];
    logic signed [ROT_W-1:0]   r_rx [STEPS+1];
    logic signed [ROT_W-1:0]   r_ry [STEPS+1];
    logic signed [32:0]        r_rz [STEPS+1];
    logic signed [VEC_W-1:0]   r_vx [STEPS+1];
    logic signed [VEC_W-1:0]   r_vy [STEPS+1];
    logic [31:0]               r_vr [STEPS+1];

    // Post stages.
    logic                      r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic signed [PROD_W-1:0]  r_p_dxc, r_p_dys, r_p_dyc, r_p_dxs;
    logic                      r_p1_ok, r_p2_ok, r_p3_ok, r_p4_ok;
    logic                      r_p4_ang;
    logic [MAG_W-1:0]          r_u, r_v2;
    logic                      r_far;
    logic [2*COORD_W-1:0]      r_ub, r_va, r_ab;
    logic [4*COORD_W-1:0]      r_sq1, r_sq2, r_sq3;
    logic                      r_out_v, r_out_in, r_out_ok;

    assign en    = !r_out_v || m_axis_tready;
    assign o_pop = en && !i_q_stat.empty;

    // Stage 0: start values of both CORDICs.
    logic signed [VEC_W-1:0] w_x0, w_y0;
    assign w_x0 = VEC_W'(i_delta.dx) <<< 16;
    assign w_y0 = VEC_W'(i_delta.dy) <<< 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0] <= i_delta.dx;
            r_dy[0] <= i_delta.dy;
            r_rx[0] <= CORDIC_START_X;
            r_ry[0] <= '0;
            r_rz[0] <= $signed({3'b000, i_orientation[ANGLE_W-3:0], (32-ANGLE_W)'(0)});
            if (w_x0 < 0) begin
                r_vx[0] <= -w_x0;
                r_vy[0] <= -w_y0;
                r_vr[0] <= HALF_TURN;
            end else begin
                r_vx[0] <= w_x0;
                r_vy[0] <= w_y0;
                r_vr[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [32:0] w_at;
        assign w_at = $signed({1'b0, atan_turn(4'(k))});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dx[k+1] <= r_dx[k];
                r_dy[k+1] <= r_dy[k];
                if (r_rz[k] >= 0) begin
                    r_rx[k+1] <= r_rx[k] - (r_ry[k] >>> k);
                    r_ry[k+1] <= r_ry[k] + (r_rx[k] >>> k);
                    r_rz[k+1] <= r_rz[k] - w_at;
                end else begin
                    r_rx[k+1] <= r_rx[k] + (r_ry[k] >>> k);
                    r_ry[k+1] <= r_ry[k] - (r_rx[k] >>> k);
                    r_rz[k+1] <= r_rz[k] + w_at;
                end
                if (r_vy[k] < 0) begin
                    r_vx[k+1] <= r_vx[k] - (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] + (r_vx[k] >>> k);
                    r_vr[k+1] <= r_vr[k] + w_at[31:0];
                end else begin
                    r_vx[k+1] <= r_vx[k] + (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] - (r_vx[k] >>> k);
                    r_vr[k+1] <= r_vr[k] - w_at[31:0];
                end
            end
        end
    end

    // Stage P1: quadrant fold, rotation products and sector check.
    logic signed [ROT_W-1:0] w_c, w_s;
    logic [31:0]             w_nrot, w_rnd;
    logic [ANGLE_W-1:0]      w_fi, w_base, w_sweep;
    logic                    w_ok;

    always_comb begin
        unique case (i_orientation[ANGLE_W-1:ANGLE_W-2])
            2'd0: begin w_c = r_rx[STEPS];  w_s = r_ry[STEPS];  end
            2'd1: begin w_c = -r_ry[STEPS]; w_s = r_rx[STEPS];  end
            2'd2: begin w_c = -r_rx[STEPS]; w_s = -r_ry[STEPS]; end
            default: begin w_c = r_ry[STEPS]; w_s = -r_rx[STEPS]; end
        endcase
        w_nrot = 32'd0 - r_vr[STEPS];
        w_rnd  = w_nrot + (32'd1 << (31 - ANGLE_W));
        if (r_dx[STEPS] == '0 && r_dy[STEPS] == '0) begin
            w_fi = '0;
        end else begin
            w_fi = w_rnd[31:32-ANGLE_W];
        end
        w_base  = i_start_angle + i_orientation;
        w_sweep = i_end_angle - i_start_angle;
        w_ok    = !i_sector_en || ((w_fi - w_base) <= w_sweep);
    end

    // Stage P2 helpers: magnitudes rounded half up to integers (Q.0).
    logic signed [SUM_W-1:0] w_su, w_sv;
    logic [SUM_W-1:0]        w_mu, w_mv;
    always_comb begin
        w_su = SUM_W'(r_p_dxc) + SUM_W'(r_p_dys);
        w_sv = SUM_W'(r_p_dyc) - SUM_W'(r_p_dxs);
        w_mu = (w_su < 0) ? SUM_W'(-w_su) : SUM_W'(w_su);
        w_mv = (w_sv < 0) ? SUM_W'(-w_sv) : SUM_W'(w_sv);
        w_mu = w_mu + (SUM_W'(1) << 29);
        w_mv = w_mv + (SUM_W'(1) << 29);
    end

    logic [4*COORD_W:0] w_lhs;
    assign w_lhs = (4*COORD_W+1)'(r_sq1) + (4*COORD_W+1)'(r_sq2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_p1_v  <= r_v[STEPS];
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_out_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dxc <= PROD_W'(r_dx[STEPS]) * PROD_W'(w_c);
            r_p_dys <= PROD_W'(r_dy[STEPS]) * PROD_W'(w_s);
            r_p_dyc <= PROD_W'(r_dy[STEPS]) * PROD_W'(w_c);
            r_p_dxs <= PROD_W'(r_dx[STEPS]) * PROD_W'(w_s);
            r_p1_ok <= w_ok;

            r_u     <= w_mu[SUM_W-1:30];
            r_v2    <= w_mv[SUM_W-1:30];
            r_p2_ok <= r_p1_ok;

            r_far   <= (r_u > MAG_W'(i_axis_first)) || (r_v2 > MAG_W'(i_axis_second))
                       || (i_axis_first == '0) || (i_axis_second == '0);
            r_ub    <= r_u[COORD_W-1:0] * i_axis_second;
            r_va    <= r_v2[COORD_W-1:0] * i_axis_first;
            r_ab    <= i_axis_first * i_axis_second;
            r_p3_ok <= r_p2_ok;

            r_sq1   <= r_ub * r_ub;
            r_sq2   <= r_va * r_va;
            r_sq3   <= r_ab * r_ab;
            r_p4_ok <= r_p3_ok && !r_far;
            // angle_ok is carried apart from r_p4_ok, which also clears far points.
            r_p4_ang <= r_p3_ok;

            r_out_in <= r_p4_ok && (w_lhs <= (4*COORD_W+1)'(r_sq3));
            r_out_ok <= r_p4_ang;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'b0, r_out_ok, r_out_in};
endmodule
`default_nettype wire

FILE: rtl/ellipse_sector_point_test.sv
// Channel  Direction  Fields (low bit first)
// s_axis   in         tdata: point_x[15:0], point_y[31:16]
// m_axis   out        tdata: inside_res[0], angle_ok[1], zero fill
// cfg      in         addr: register index, data: register value
// One point is taken per cycle while the queue is not full; each result passes the queue,
// the two 16-step CORDIC pipelines and five post stages (P1 to P4 and the output register).
// Reset is synchronous and active low; no input is taken in the cycle after it.
// A stalled output freezes the pipeline and a four-entry queue absorbs the input side.
`default_nettype none
`include "ellipse_sector_point_test_defines.svh"
module ellipse_sector_point_test import esp_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [2*COORD_W-1:0] s_axis_tdata,   // point_x, point_y
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // inside_res, angle_ok, zero fill
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [2:0]           i_cfg_addr,
    input  wire [COORD_W-1:0]   i_cfg_data
);
    logic signed [COORD_W-1:0] r_center_x, r_center_y;
    logic [COORD_W-1:0]        r_axis_first, r_axis_second;
    logic [ANGLE_W-1:0]        r_orientation, r_start_angle, r_end_angle;
    logic                      r_sector_en;
    t_q_stat                   w_q_stat;
    t_delta                    w_push_data, w_head;
    logic                      w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_axis_first  <= '0;
            r_axis_second <= '0;
            r_orientation <= '0;
            r_start_angle <= '0;
            r_end_angle   <= '0;
            r_sector_en   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_CENTER_X:    r_center_x    <= $signed(i_cfg_data);
                REG_CENTER_Y:    r_center_y    <= $signed(i_cfg_data);
                REG_AXIS_FIRST:  r_axis_first  <= i_cfg_data;
                REG_AXIS_SECOND: r_axis_second <= i_cfg_data;
                REG_ORIENTATION: r_orientation <= i_cfg_data[ANGLE_W-1:0];
                REG_START_ANGLE: r_start_angle <= i_cfg_data[ANGLE_W-1:0];
                REG_END_ANGLE:   r_end_angle   <= i_cfg_data[ANGLE_W-1:0];
                default:         r_sector_en   <= i_cfg_data[0];
            endcase
        end
    end

    esp_front u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_delta    (w_push_data)
    );

    esp_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (w_push),
        .i_data (w_push_data),
        .i_pop  (w_pop),
        .o_data (w_head),
        .o_stat (w_q_stat)
    );

    esp_back u_back (
        .i_clk, .i_rst_n,
        .i_q_stat      (w_q_stat),
        .i_delta       (w_head),
        .o_pop         (w_pop),
        .i_axis_first  (r_axis_first),
        .i_axis_second (r_axis_second),
        .i_orientation (r_orientation),
        .i_start_angle (r_start_angle),
        .i_end_angle   (r_end_angle),
        .i_sector_en   (r_sector_en),
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    `ESP_IMPLY(a_inside_needs_angle, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "angle")
    `ESP_IMPLY(a_zero_axis_outside, m_axis_tvalid && (r_axis_first == '0), !m_axis_tdata[0], "axis")
    `ESP_IMPLY(a_no_push_when_full, w_q_stat.full, !w_push, "queue overrun")
endmodule
`default_nettype wire
